FILE: rtl/brf_pkg.sv
// Shared constants, command type and pointer helpers for the byte ring FIFO.
package brf_pkg;

  localparam int DEPTH   = 64;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int CFG_W   = 7;
  localparam int REQ_W   = 7;
  localparam int CNT_W   = 7;
  localparam int FILL_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(DEPTH);

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_PEEK  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] data;
    logic              eob;
    logic [REQ_W-1:0]  req;
  } cmd_t;

  // Clamp the programmed capacity to 1..DEPTH.
  function automatic logic [CFG_W-1:0] cap_effective(input logic [CFG_W-1:0] cap);
    logic [CFG_W-1:0] c;
    c = cap;
    if (c == '0) c = CFG_W'(1);
    if (c > CFG_W'(DEPTH)) c = CFG_W'(DEPTH);
    return c;
  endfunction

  // Step a position by one, wrapping to zero at the capacity.
  function automatic logic [AW-1:0] pos_advance(input logic [AW-1:0] pos,
                                                input logic [CFG_W-1:0] cap);
    logic [CFG_W-1:0] n;
    n = CFG_W'(pos) + CFG_W'(1);
    return (n >= cap) ? '0 : AW'(n);
  endfunction

endpackage

FILE: rtl/brf_ram.sv
// Generic single-write, single-read RAM with registered, enabled read port.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata <= mem_r[raddr];
  end

endmodule

FILE: rtl/brf_front.sv
// Front end: takes input transfers, decodes the action and drops unknown codes.
module brf_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,
  input  logic [1:0]                    in_tuser,
  input  logic                          in_tlast,
  input  logic                          q_full,
  output logic                          push,
  output brf_pkg::cmd_t                 cmd
);

  assign in_tready = !q_full;

  always_comb begin
    cmd.kind = in_tuser;
    cmd.data = in_tdata[brf_pkg::BYTE_W-1:0];
    cmd.eob  = in_tlast;
    cmd.req  = in_tdata[brf_pkg::BYTE_W +: brf_pkg::REQ_W];
  end

  // Unknown action is taken off the bus but never reaches the back end.
  assign push = in_tvalid && in_tready && (in_tuser != brf_pkg::ACT_NONE);

endmodule

FILE: rtl/brf_cmd_q.sv
// Short command queue between the front and back ends.
module brf_cmd_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  brf_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          q_valid,
  output brf_pkg::cmd_t q_cmd,
  input  logic          pop
);

  brf_pkg::cmd_t           ent_r [brf_pkg::Q_DEPTH];
  logic [brf_pkg::Q_AW-1:0] wp_r, wp_nxt;
  logic [brf_pkg::Q_AW-1:0] rp_r, rp_nxt;
  logic [brf_pkg::Q_AW:0]   cnt_r, cnt_nxt;
  logic                     do_push, do_pop;

  assign full    = (cnt_r == (brf_pkg::Q_AW + 1)'(brf_pkg::Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = ent_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wp_nxt  = do_push ? wp_r + brf_pkg::Q_AW'(1) : wp_r;
    rp_nxt  = do_pop  ? rp_r + brf_pkg::Q_AW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + (brf_pkg::Q_AW + 1)'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - (brf_pkg::Q_AW + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_cmd;
  end

endmodule

FILE: rtl/brf_back.sv
// Back end: executes commands against the ring store and drives the result channel.
module brf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [brf_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       q_valid,
  input  brf_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [23:0]                out_tdata,
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast
);

  localparam int AW = brf_pkg::AW;
  localparam int CW = brf_pkg::CW;

  logic [brf_pkg::CFG_W-1:0] cap_r;
  logic [brf_pkg::CFG_W-1:0] cap_eff;

  logic [AW-1:0]             rd_pos_r, rd_pos_nxt;
  logic [AW-1:0]             wr_pos_r, wr_pos_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [brf_pkg::CNT_W-1:0] blk_r, blk_nxt;

  logic                      run_r, run_nxt;
  logic                      run_consume_r, run_consume_nxt;
  logic [AW-1:0]             run_pos_r, run_pos_nxt;
  logic [brf_pkg::REQ_W-1:0] run_left_r, run_left_nxt;
  logic [brf_pkg::REQ_W-1:0] run_n_r, run_n_nxt;

  logic                       m_valid_r, m_valid_nxt;
  logic                       m_bvalid_r, m_bvalid_nxt;
  logic                       m_acc_r, m_acc_nxt;
  logic                       m_last_r, m_last_nxt;
  logic [brf_pkg::CNT_W-1:0]  m_cnt_r, m_cnt_nxt;
  logic [brf_pkg::FILL_W-1:0] m_fill_r, m_fill_nxt;

  logic                       adv;
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [brf_pkg::BYTE_W-1:0] ram_q;
  logic [brf_pkg::REQ_W-1:0]  fill7, n_take;
  logic [CW-1:0]              count_inc;
  logic [brf_pkg::CNT_W-1:0]  blk_inc;
  logic                       lst;

  assign cap_eff = brf_pkg::cap_effective(cap_r);
  assign adv     = !m_valid_r || out_tready;
  assign q_pop   = adv && !run_r && q_valid;
  assign fill7   = brf_pkg::REQ_W'(count_r);
  assign n_take  = (q_cmd.req < fill7) ? q_cmd.req : fill7;

  always_comb begin
    rd_pos_nxt      = rd_pos_r;
    wr_pos_nxt      = wr_pos_r;
    count_nxt       = count_r;
    blk_nxt         = blk_r;
    run_nxt         = run_r;
    run_consume_nxt = run_consume_r;
    run_pos_nxt     = run_pos_r;
    run_left_nxt    = run_left_r;
    run_n_nxt       = run_n_r;
    m_valid_nxt     = m_valid_r;
    m_bvalid_nxt    = m_bvalid_r;
    m_acc_nxt       = m_acc_r;
    m_last_nxt      = m_last_r;
    m_cnt_nxt       = m_cnt_r;
    m_fill_nxt      = m_fill_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = run_pos_r;
    count_inc       = count_r + CW'(1);
    blk_inc         = (blk_r == brf_pkg::CNT_MAX) ? blk_r : blk_r + brf_pkg::CNT_W'(1);
    lst             = (run_left_r == brf_pkg::REQ_W'(1));

    if (adv) begin
      m_valid_nxt  = 1'b0;
      m_bvalid_nxt = 1'b0;
      m_acc_nxt    = 1'b0;
      m_last_nxt   = 1'b0;
      m_cnt_nxt    = '0;
      m_fill_nxt   = brf_pkg::FILL_W'(count_r);
      if (run_r) begin
        // one byte of a read or peek run per cycle while the output is not stalled
        ram_re       = 1'b1;
        m_valid_nxt  = 1'b1;
        m_bvalid_nxt = 1'b1;
        m_last_nxt   = lst;
        m_cnt_nxt    = lst ? brf_pkg::CNT_W'(run_n_r) : '0;
        run_pos_nxt  = brf_pkg::pos_advance(run_pos_r, cap_eff);
        run_left_nxt = run_left_r - brf_pkg::REQ_W'(1);
        if (lst) run_nxt = 1'b0;
        if (run_consume_r) begin
          rd_pos_nxt = brf_pkg::pos_advance(run_pos_r, cap_eff);
          count_nxt  = count_r - CW'(1);
          m_fill_nxt = brf_pkg::FILL_W'(count_r - CW'(1));
        end
      end else if (q_valid) begin
        case (q_cmd.kind)
          brf_pkg::ACT_WRITE: begin
            m_valid_nxt = 1'b1;
            if (brf_pkg::CFG_W'(count_r) < cap_eff) begin
              ram_we     = 1'b1;
              wr_pos_nxt = brf_pkg::pos_advance(wr_pos_r, cap_eff);
              count_nxt  = count_inc;
              blk_nxt    = blk_inc;
              m_acc_nxt  = 1'b1;
              m_fill_nxt = brf_pkg::FILL_W'(count_inc);
            end
            if (q_cmd.eob) begin
              m_last_nxt = 1'b1;
              m_cnt_nxt  = blk_nxt;
              blk_nxt    = '0;
            end
          end
          brf_pkg::ACT_READ, brf_pkg::ACT_PEEK: begin
            if (n_take == '0) begin
              m_valid_nxt = 1'b1;
              m_last_nxt  = 1'b1;
            end else begin
              run_nxt         = 1'b1;
              run_consume_nxt = (q_cmd.kind == brf_pkg::ACT_READ);
              run_pos_nxt     = rd_pos_r;
              run_left_nxt    = n_take;
              run_n_nxt       = n_take;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= brf_pkg::CAP_RESET;
      rd_pos_r   <= '0;
      wr_pos_r   <= '0;
      count_r    <= '0;
      blk_r      <= '0;
      run_r      <= 1'b0;
      m_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      rd_pos_r   <= rd_pos_nxt;
      wr_pos_r   <= wr_pos_nxt;
      count_r    <= count_nxt;
      blk_r      <= blk_nxt;
      run_r      <= run_nxt;
      m_valid_r  <= m_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_consume_r <= run_consume_nxt;
    run_pos_r     <= run_pos_nxt;
    run_left_r    <= run_left_nxt;
    run_n_r       <= run_n_nxt;
    m_bvalid_r    <= m_bvalid_nxt;
    m_acc_r       <= m_acc_nxt;
    m_last_r      <= m_last_nxt;
    m_cnt_r       <= m_cnt_nxt;
    m_fill_r      <= m_fill_nxt;
  end

  brf_ram #(
    .WIDTH(brf_pkg::BYTE_W),
    .DEPTH(brf_pkg::DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_pos_r),
    .wdata(q_cmd.data),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // RAM output holds while stalled, so it serves as the output data register.
  assign out_tvalid = m_valid_r;
  assign out_tlast  = m_last_r;
  assign out_tuser  = {m_acc_r, m_bvalid_r};
  assign out_tdata  = {2'b00, m_fill_r, m_cnt_r,
                       (m_bvalid_r ? ram_q : {brf_pkg::BYTE_W{1'b0}})};

endmodule

FILE: rtl/byte_ring_fifo_top.sv
// Top level of the byte ring FIFO: front end, command queue and back end.
// Path: with the path clear, a write or empty-run result is registered through the command
//   queue and the output register; the first byte of a read or peek run also waits for the run set-up.
// Writes: one per cycle unless stalled. Read or peek of n bytes: a set-up step in the back
//   end, then n results at one per cycle unless stalled; an empty run gives one result.
// The byte rate is set by the single store read port: one byte per cycle unless stalled.
// Reset (rst_n low, synchronous): pointers, counts and queue cleared, capacity 64;
//   store not cleared.
module byte_ring_fifo_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: capacity_in_use
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [14:8] request_length, [15] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic        in_tlast,   // end_of_block
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [14:8] transferred_count,
                                  // [21:15] fill_level, [23:22] zero
  output logic [1:0]  out_tuser,  // [0] byte_valid, [1] accepted
  output logic        out_tlast   // last
);

  logic          q_full;
  logic          push;
  logic          q_valid;
  logic          q_pop;
  brf_pkg::cmd_t push_cmd;
  brf_pkg::cmd_t q_cmd;

  // Front end: decode each input transfer into a command.
  brf_front u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .in_tlast (in_tlast),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Queue decouples input acceptance from read runs and output stalls.
  brf_cmd_q u_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (q_pop)
  );

  // Back end owns the store, the pointers, the fill and block counts.
  brf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

FILE: rtl/brf_checker.sv
// Port-level assertions for the byte ring FIFO, bound to the top level.
module brf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [6:0]  cfg_wdata,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("result changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("byte and write acceptance flagged together");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[14:8] == 7'd0)
    else $error("count reported on non-final result");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[21:15] != 7'd0
                                   && out_tdata[21:15] <= 7'(brf_pkg::DEPTH))
    else $error("accepted write with impossible fill level");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind byte_ring_fifo_top brf_checker u_chk (.*);

FILE: tb/tb_top.sv
// Self-checking bench for the byte ring FIFO: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import brf_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 12;      // quiet time before a capacity write
  localparam int unsigned TAIL_CYCLES   = 20;      // idle time after the last result
  localparam int unsigned CYCLE_LIMIT   = 400000;  // hard stop for a hung run
  localparam int unsigned MAX_PRINTS    = 60;

  // One input item, as the bench sees it.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] value;
    logic       eob;
    logic [6:0] req_len;
  } ring_op_t;

  // One result, field by field.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       accepted;
    logic       last;
    logic [6:0] count;
    logic [6:0] fill;
  } reply_t;

  // Row of the directed table: either a capacity write or an item, the latter with
  // an optional hand-written result.
  typedef struct packed {
    logic       is_cfg;
    logic [6:0] cfg_val;
    ring_op_t   op;
    logic       typed;
    reply_t     reply;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] data_byte, [14:8] request_length, [15] zero
  logic [1:0]  in_tuser;   // [1:0] action
  logic        in_tlast;   // end_of_block
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [7:0] out_byte, [14:8] transferred_count, [21:15] fill_level
  logic [1:0]  out_tuser;  // [0] byte_valid, [1] accepted
  logic        out_tlast;  // last

  byte_ring_fifo_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the ring: store, positions, fill, block tally and capacity.
  // ring_written tracks which slots hold a real byte, so that random reads never
  // walk onto a slot that was never filled (possible after a capacity change).
  // ---------------------------------------------------------------------------
  logic [7:0] ring_mem [DEPTH];
  bit         ring_written [DEPTH];
  logic [5:0] rd_slot     = '0;
  logic [5:0] wr_slot     = '0;
  logic [6:0] held        = '0;
  logic [6:0] blk_accepts = '0;
  logic [6:0] cap_reg     = 7'd64;

  reply_t   pending_replies [$];  // results still owed by the block, oldest first
  dir_row_t dir_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  bit send_idles   = 1'b1;
  bit recv_idles   = 1'b1;
  bit hold_off_req = 1'b0;

  // Capacity as the block applies it: 0 behaves as 1, anything above DEPTH as DEPTH.
  function automatic int unsigned eff_capacity();
    if (cap_reg == '0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return cap_reg;
  endfunction

  function automatic logic [5:0] next_slot(input logic [5:0] pos, input int unsigned cap);
    int unsigned n;
    n = pos + 1;
    return (n >= cap) ? 6'd0 : 6'(n);
  endfunction

  // Trim a read length so that the run stops short of any never-written slot.
  function automatic logic [6:0] readable_run(input logic [6:0] want);
    int unsigned n;
    int unsigned k;
    int unsigned cap;
    logic [5:0]  pos;
    n   = (want < held) ? want : held;
    cap = eff_capacity();
    pos = rd_slot;
    for (k = 0; k < n; k++) begin
      if (!ring_written[pos]) return 7'(k);
      pos = next_slot(pos, cap);
    end
    return want;
  endfunction

  // Advance the mirror by one accepted item and queue the results it owes.
  // A typed row queues its hand-written result in place of the computed ones.
  task automatic ring_apply(input ring_op_t op, input bit use_typed, input reply_t typed_reply);
    int unsigned cap;
    int unsigned n;
    int unsigned k;
    int unsigned fill_now;
    logic [5:0]  pos;
    reply_t      r;
    cap = eff_capacity();
    r   = '0;
    case (op.action)
      ACT_WRITE: begin
        // dropped when full; the block tally only counts stored bytes
        if (held < cap) begin
          ring_mem[wr_slot]     = op.value;
          ring_written[wr_slot] = 1'b1;
          wr_slot               = next_slot(wr_slot, cap);
          held                  = held + 7'd1;
          r.accepted            = 1'b1;
          if (blk_accepts != CNT_MAX) blk_accepts = blk_accepts + 7'd1;
        end
        if (op.eob) begin
          r.last      = 1'b1;
          r.count     = blk_accepts;
          blk_accepts = '0;
        end
        r.fill = held;
        if (!use_typed) pending_replies.push_back(r);
      end
      ACT_READ, ACT_PEEK: begin
        n        = (op.req_len < held) ? op.req_len : held;
        pos      = rd_slot;
        fill_now = held;
        if (n == 0) begin
          // nothing to deliver: one empty, marked result
          r.last = 1'b1;
          r.fill = held;
          if (!use_typed) pending_replies.push_back(r);
        end
        for (k = 0; k < n; k++) begin
          r            = '0;
          r.out_byte   = ring_mem[pos];
          r.byte_valid = 1'b1;
          r.last       = (k + 1 == n);
          r.count      = r.last ? 7'(n) : 7'd0;
          pos          = next_slot(pos, cap);
          if (op.action == ACT_READ) fill_now--;
          r.fill = 7'(fill_now);
          if (!use_typed) pending_replies.push_back(r);
        end
        // a peek leaves the ring untouched
        if (op.action == ACT_READ) begin
          rd_slot = pos;
          held    = 7'(fill_now);
        end
      end
      default: ;  // unknown action: swallowed, no result
    endcase
    if (use_typed) pending_replies.push_back(typed_reply);
  endtask

  function automatic void add_row(input logic is_cfg, input logic [6:0] cfg_val,
                                  input ring_op_t op, input logic typed, input reply_t reply);
    dir_row_t row;
    row.is_cfg  = is_cfg;
    row.cfg_val = cfg_val;
    row.op      = op;
    row.typed   = typed;
    row.reply   = reply;
    dir_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < MAX_PRINTS)
      $display("tb_top: mismatch on %s at cycle %0d: got %0d, want %0d",
               what, cycle_count, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender side. Called at a falling edge; returns at the falling edge after the
  // transfer, with tvalid left high so back-to-back items need no re-raise.
  // ---------------------------------------------------------------------------
  task automatic send_op(input ring_op_t op, input bit use_typed, input reply_t typed_reply);
    int unsigned gap;
    gap = send_idles ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, op.req_len, op.value};
    in_tuser  <= op.action;
    in_tlast  <= op.eob;
    do @(posedge clk); while (!in_tready);
    ring_apply(op, use_typed, typed_reply);
    @(negedge clk);
  endtask

  // Stop offering and wait until every owed result has been transferred.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_replies.size() != 0);
  endtask

  // Capacity is only written with the block idle. Swallowed items leave no trace
  // in the queue, hence the extra settle time.
  task automatic write_capacity(input logic [6:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we  <= 1'b0;
    cap_reg  = value;
  endtask

  // Random traffic at one capacity: write blocks of random length, reads and
  // peeks of mostly short runs, some oversized requests, some noise.
  task automatic run_phase(input logic [6:0] cap, input int unsigned n_items);
    int unsigned done_items;
    int unsigned block_left;
    int unsigned pick;
    int unsigned len_sel;
    bit          paused;
    ring_op_t    op;
    write_capacity(cap);
    send_idles = ($urandom_range(0, 3) != 0);
    recv_idles = ($urandom_range(0, 3) != 0);
    done_items = 0;
    block_left = 0;
    paused     = 1'b0;
    while (done_items < n_items) begin
      // halfway through, the sender stands back until the block has caught up
      if (!paused && done_items >= n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      op.value   = 8'($urandom_range(0, 255));
      op.eob     = 1'($urandom_range(0, 1));
      op.req_len = 7'($urandom_range(0, 127));
      pick       = $urandom_range(0, 99);
      if (pick < 8) begin
        op.action = ACT_NONE;
      end else if (pick < 13) begin
        // broken block: random end marker, tally restarts the pattern
        op.action  = ACT_WRITE;
        block_left = 0;
      end else if (pick < 60) begin
        op.action = ACT_WRITE;
        if (block_left == 0) block_left = $urandom_range(1, 8);
        block_left--;
        op.eob = (block_left == 0);
      end else begin
        op.action = (pick < 82) ? ACT_READ : ACT_PEEK;
        len_sel   = $urandom_range(0, 19);
        if (len_sel < 10)      op.req_len = 7'($urandom_range(1, 8));
        else if (len_sel < 13) op.req_len = 7'd0;
        else if (len_sel < 15) op.req_len = 7'd64;
        op.req_len = readable_run(op.req_len);
      end
      if (op.action != ACT_NONE) done_items++;
      send_op(op, 1'b0, '0);
    end
  endtask

  // One block of 151 accepted bytes, enough to saturate the block tally. The
  // receiver holds off at the start, so the block backs up and stalls its input.
  task automatic run_long_block();
    int unsigned i;
    ring_op_t    op;
    write_capacity(7'd64);
    send_idles   = 1'b0;
    recv_idles   = 1'b0;
    hold_off_req = 1'b1;
    for (i = 1; i <= 150; i++) begin
      op = '{ACT_WRITE, 8'($urandom_range(0, 255)), 1'b0, 7'($urandom_range(0, 127))};
      send_op(op, 1'b0, '0);
      if (i % 40 == 0) begin
        op = '{ACT_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 7'd40};
        op.req_len = readable_run(op.req_len);
        send_op(op, 1'b0, '0);
      end
    end
    op = '{ACT_WRITE, 8'($urandom_range(0, 255)), 1'b1, 7'd0};
    send_op(op, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, long block, random phases, then wind down.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ACT_WRITE;
    in_tlast  = 1'b0;

    // fresh from reset: empty read and empty peek
    add_row(1'b0, '0, '{ACT_READ, 8'h00, 1'b0, 7'd64}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 7'd0, 7'd0});
    add_row(1'b0, '0, '{ACT_PEEK, 8'h00, 1'b0, 7'd0},  1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 7'd0, 7'd0});
    // unknown action with every field at its top: swallowed
    add_row(1'b0, '0, '{ACT_NONE, 8'hFF, 1'b1, 7'd127}, 1'b0, '0);
    // a two-byte block at the extremes of the data byte, then one more write
    add_row(1'b0, '0, '{ACT_WRITE, 8'h00, 1'b0, 7'd0},  1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 7'd1});
    add_row(1'b0, '0, '{ACT_WRITE, 8'hFF, 1'b1, 7'd0},  1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 7'd2, 7'd2});
    add_row(1'b0, '0, '{ACT_WRITE, 8'hA5, 1'b0, 7'd127}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 7'd3});
    add_row(1'b0, '0, '{ACT_PEEK, 8'h00, 1'b0, 7'd64}, 1'b0, '0);
    add_row(1'b0, '0, '{ACT_READ, 8'h00, 1'b0, 7'd0},  1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 7'd0, 7'd3});
    add_row(1'b0, '0, '{ACT_READ, 8'h00, 1'b0, 7'd2},  1'b0, '0);
    add_row(1'b0, '0, '{ACT_NONE, 8'h00, 1'b0, 7'd0},  1'b0, '0);
    // shrink the capacity with a byte still stored; fill up and overflow
    add_row(1'b1, 7'd2, '0, 1'b0, '0);
    add_row(1'b0, '0, '{ACT_WRITE, 8'h5A, 1'b0, 7'd0}, 1'b0, '0);
    add_row(1'b0, '0, '{ACT_WRITE, 8'h33, 1'b1, 7'd0}, 1'b0, '0);
    add_row(1'b0, '0, '{ACT_READ, 8'h00, 1'b0, 7'd64}, 1'b0, '0);
    // capacity zero behaves as one slot
    add_row(1'b1, 7'd0, '0, 1'b0, '0);
    add_row(1'b0, '0, '{ACT_WRITE, 8'h81, 1'b0, 7'd0}, 1'b0, '0);
    add_row(1'b0, '0, '{ACT_WRITE, 8'h7E, 1'b1, 7'd0}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 7'd1, 7'd1});
    add_row(1'b0, '0, '{ACT_PEEK, 8'h00, 1'b0, 7'd1},  1'b0, '0);
    add_row(1'b0, '0, '{ACT_READ, 8'hFF, 1'b1, 7'd127}, 1'b0, '0);
    // capacity above DEPTH behaves as DEPTH
    add_row(1'b1, 7'd127, '0, 1'b0, '0);
    add_row(1'b0, '0, '{ACT_WRITE, 8'hC3, 1'b1, 7'd127}, 1'b0, '0);
    add_row(1'b0, '0, '{ACT_PEEK, 8'hFF, 1'b1, 7'd127}, 1'b0, '0);
    add_row(1'b0, '0, '{ACT_READ, 8'h00, 1'b0, 7'd1},  1'b0, '0);
    add_row(1'b1, 7'd64, '0, 1'b0, '0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_capacity(dir_rows[i].cfg_val);
      else send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].reply);
    end

    run_long_block();
    run_phase(7'd1, 30);
    run_phase(7'd127, 30);
    run_phase(7'd0, 25);
    run_phase(7'($urandom_range(2, 63)), 35);
    run_phase(7'd64, 35);
    run_phase(7'($urandom_range(2, 9)), 30);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall before each result, and one long hold-off on request,
  // counted here in cycles.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    int unsigned held_cycles;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        held_cycles = 0;
        while (held_cycles < HOLD_CYCLES) begin
          @(negedge clk);
          held_cycles++;
        end
        hold_off_req = 1'b0;
      end
      stall = recv_idles ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Scoreboard: each result transfer against the oldest owed result.
  reply_t head_reply;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result with nothing owed", out_tdata[7:0], 0);
      end else begin
        head_reply = pending_replies.pop_front();
        if (out_tdata[7:0] !== head_reply.out_byte)
          report_mismatch("out_byte", out_tdata[7:0], head_reply.out_byte);
        if (out_tuser[0] !== head_reply.byte_valid)
          report_mismatch("byte_valid", out_tuser[0], head_reply.byte_valid);
        if (out_tuser[1] !== head_reply.accepted)
          report_mismatch("accepted", out_tuser[1], head_reply.accepted);
        if (out_tlast !== head_reply.last)
          report_mismatch("last", out_tlast, head_reply.last);
        if (out_tdata[14:8] !== head_reply.count)
          report_mismatch("transferred_count", out_tdata[14:8], head_reply.count);
        if (out_tdata[21:15] !== head_reply.fill)
          report_mismatch("fill_level", out_tdata[21:15], head_reply.fill);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule

FILE: sim.f
rtl/brf_pkg.sv
rtl/brf_ram.sv
rtl/brf_front.sv
rtl/brf_cmd_q.sv
rtl/brf_back.sv
rtl/byte_ring_fifo_top.sv
rtl/brf_checker.sv
tb/tb_top.sv
